FILE: src/sdiv_pkg.sv
`default_nettype none

package sdiv_pkg;

    // Width of the operand and quotient ports
    localparam int PORT_WIDTH = 64;

    // Control that travels beside each operand pair through the pipe
    typedef struct packed {
        logic valid;     // stage holds a live item
        logic negate;    // operand signs differ: quotient gets negated
        logic div_zero;  // divisor was zero
    } t_ctl;

endpackage

`default_nettype wire

FILE: src/sdiv_prep.sv
`default_nettype none

module sdiv_prep #(
    parameter int W = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_take,
    input  wire logic [sdiv_pkg::PORT_WIDTH-1:0]    i_dividend,
    input  wire logic [sdiv_pkg::PORT_WIDTH-1:0]    i_divisor,
    output logic      [W-1:0]                       o_num,
    output logic      [W-1:0]                       o_den,
    output sdiv_pkg::t_ctl                          o_ctl
);
    import sdiv_pkg::*;

    logic [W-1:0] a_w;
    logic [W-1:0] b_w;
    logic         a_neg;
    logic         b_neg;
    logic [W-1:0] n_num;
    logic [W-1:0] n_den;
    t_ctl         n_ctl;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;
    t_ctl         r_ctl;

    always_comb begin
        a_w   = i_dividend[W-1:0];
        b_w   = i_divisor[W-1:0];
        a_neg = a_w[W-1];
        b_neg = b_w[W-1];
        // most negative value maps to 2^(W-1) as an unsigned magnitude
        n_num = a_neg ? (~a_w + W'(1)) : a_w;
        n_den = b_neg ? (~b_w + W'(1)) : b_w;
        n_ctl.valid    = i_take;
        n_ctl.negate   = a_neg ^ b_neg;
        n_ctl.div_zero = (b_w == '0);
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

FILE: src/sdiv_cell.sv
`default_nettype none

module sdiv_cell #(
    parameter int W = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [W-1:0]   i_rem,
    input  wire logic [W-1:0]   i_num,
    input  wire logic [W-1:0]   i_den,
    input  wire logic [W-1:0]   i_quo,
    input  wire sdiv_pkg::t_ctl i_ctl,
    output logic      [W-1:0]   o_rem,
    output logic      [W-1:0]   o_num,
    output logic      [W-1:0]   o_den,
    output logic      [W-1:0]   o_quo,
    output sdiv_pkg::t_ctl      o_ctl
);
    import sdiv_pkg::*;

    logic [W-1:0] trial;
    logic         fits;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;
    logic [W-1:0] r_quo;
    t_ctl         r_ctl;

    // remainder stays below den <= 2^(W-1), so the shifted trial fits W bits
    always_comb begin
        trial = {i_rem[W-2:0], i_num[W-1]};
        fits  = (trial >= i_den);
        n_rem = fits ? (trial - i_den) : trial;
        n_quo = {i_quo[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= {i_num[W-2:0], 1'b0};
        r_den <= i_den;
        r_quo <= n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

FILE: src/sdiv_post.sv
`default_nettype none

module sdiv_post #(
    parameter int W = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [W-1:0]                   i_quo,
    input  wire sdiv_pkg::t_ctl                 i_ctl,
    output logic                                o_valid,
    output logic [sdiv_pkg::PORT_WIDTH-1:0]     o_quotient,
    output logic                                o_divide_by_zero
);
    import sdiv_pkg::*;

    logic signed [W-1:0]          q_s;
    logic [PORT_WIDTH-1:0]        n_quotient;
    logic [PORT_WIDTH-1:0]        r_quotient;
    logic                         r_dbz;
    logic                         r_valid;

    always_comb begin
        q_s = i_ctl.negate ? signed'(~i_quo + W'(1)) : signed'(i_quo);
        if (i_ctl.div_zero) begin
            n_quotient = '0;
        end else begin
            n_quotient = PORT_WIDTH'(q_s);
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
        r_dbz      <= i_ctl.div_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quotient;
    assign o_divide_by_zero = r_dbz;

endmodule

`default_nettype wire

FILE: src/signed_divider_64_core.sv
`default_nettype none

// Signed integer divider, quotient truncated toward zero.
// Input: an operand pair (i_dividend, i_divisor) is transferred on a rising
// edge where start is high and busy is low. busy is high while reset is held
// and in the cycle after it; from then on a pair may be transferred in every cycle.
// Output: o_valid strobes for one cycle with o_quotient and o_divide_by_zero.
// The receiver cannot stall; results come out in input order.
// Pipeline: a register for the operand magnitudes, a row of DATA_WIDTH restoring
// cells (one per quotient bit), and a register for the sign fix.
// Throughput: one pair per cycle.
// Only the low DATA_WIDTH bits of each operand are used, read as signed; the
// quotient is sign-extended to 64 bits. A zero divisor gives quotient 0 with
// o_divide_by_zero set; most negative over minus one wraps to most negative.
// Reset clears the valid bits of every stage; items in flight are dropped.
module signed_divider_64_core #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sdiv_pkg::PORT_WIDTH-1:0]    i_dividend,
    input  wire logic [sdiv_pkg::PORT_WIDTH-1:0]    i_divisor,
    output logic                                    o_valid,
    output logic [sdiv_pkg::PORT_WIDTH-1:0]         o_quotient,
    output logic                                    o_divide_by_zero
);
    import sdiv_pkg::*;

    localparam int W = DATA_WIDTH;

    logic         r_up;
    logic         take;
    logic [W-1:0] rem_c [W+1];
    logic [W-1:0] num_c [W+1];
    logic [W-1:0] den_c [W+1];
    logic [W-1:0] quo_c [W+1];
    t_ctl         ctl_c [W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= 1'b0;
        end else begin
            r_up <= 1'b1;
        end
    end

    assign busy = !r_up;
    assign take = start && !busy;

    sdiv_prep #(.W(W)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_num      (num_c[0]),
        .o_den      (den_c[0]),
        .o_ctl      (ctl_c[0])
    );

    assign rem_c[0] = '0;
    assign quo_c[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        sdiv_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (rem_c[k]),
            .i_num   (num_c[k]),
            .i_den   (den_c[k]),
            .i_quo   (quo_c[k]),
            .i_ctl   (ctl_c[k]),
            .o_rem   (rem_c[k+1]),
            .o_num   (num_c[k+1]),
            .o_den   (den_c[k+1]),
            .o_quo   (quo_c[k+1]),
            .o_ctl   (ctl_c[k+1])
        );
    end

    sdiv_post #(.W(W)) u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_quo            (quo_c[W]),
        .i_ctl            (ctl_c[W]),
        .o_valid          (o_valid),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // every strobe comes from a transfer exactly the pipe depth earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, W + 2))
        else $error("result strobe without matching transfer");

    // zero-divisor flag follows the divisor of that transfer
    a_dbz_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_divide_by_zero == $past(i_divisor[W-1:0] == '0, W + 2)))
        else $error("divide-by-zero flag mismatch");

    // a flagged result always carries a zero quotient
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("nonzero quotient on divide by zero");

endmodule

`default_nettype wire
